>>> hdl/section_region_address_translator_assert.svh
// ----------------------------------------------------------------------------
// Section region address translator assertion macros
// Concurrent assertion wrappers clocked on clock; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SECTION_REGION_ADDRESS_TRANSLATOR_ASSERT_SVH
`define SECTION_REGION_ADDRESS_TRANSLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SRAT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SRAT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SRAT_ASSERT(label, prop, msg)
`define SRAT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> hdl/srat_pkg.sv
// ----------------------------------------------------------------------------
// Section region address translator package
// Widths, field positions, operation codes and helpers for the translator.
// ----------------------------------------------------------------------------
package srat_pkg;

   localparam int MAX_REGIONS = 32;
   localparam int SLOT_LIMIT  = 32;
   localparam int LANES       = (MAX_REGIONS < SLOT_LIMIT) ? MAX_REGIONS : SLOT_LIMIT;

   localparam int FUNC_W  = 2;
   localparam int SLOT_W  = 5;
   localparam int ADDR_W  = 32;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 6;

   localparam logic [INDEX_W-1:0] INDEX_MISS = '1;

   // Request tdata layout, lowest bit first.
   localparam int REQ_SLOT_LSB  = 0;
   localparam int REQ_VBASE_LSB = REQ_SLOT_LSB + SLOT_W;
   localparam int REQ_VSPAN_LSB = REQ_VBASE_LSB + ADDR_W;
   localparam int REQ_RBASE_LSB = REQ_VSPAN_LSB + ADDR_W;
   localparam int REQ_RSPAN_LSB = REQ_RBASE_LSB + ADDR_W;
   localparam int REQ_ADDR_LSB  = REQ_RSPAN_LSB + ADDR_W;
   localparam int REQ_USED_W    = REQ_ADDR_LSB + ADDR_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest bit first.
   localparam int RSP_INDEX_LSB = 0;
   localparam int RSP_XLAT_LSB  = RSP_INDEX_LSB + INDEX_W;
   localparam int RSP_OFF_LSB   = RSP_XLAT_LSB + ADDR_W;
   localparam int RSP_USED_W    = RSP_OFF_LSB + ADDR_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_FWD   = 2'd1,
      FUNC_REV   = 2'd2
   } func_type;

   function automatic logic is_query(func_type f);
      return (f == FUNC_FWD) || (f == FUNC_REV);
   endfunction

endpackage

>>> hdl/section_region_address_translator.sv
// ----------------------------------------------------------------------------
// Section region address translator
// Maps virtual addresses to raw file offsets and back through a region table.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: tuser selects the operation (write an
//   entry, virtual-to-raw lookup, raw-to-virtual lookup) and tdata carries the
//   slot, the four region values and the lookup address.
//   rsp_* returns exactly one result per item, in order: tuser is the hit flag,
//   tdata holds region index, translated address and offset in the region.
//   csr_* writes the number of active regions searched by lookups; it may be
//   written only while no item is in flight.
// A request transfer reaches rsp_* through five register stages plus the
// output register. One item is taken per cycle while the pipeline advances;
// a write entry waits while earlier lookups that still read the table are
// in the compare and select stages.
// Reset clears the active region count and empties the pipeline; table
// entries hold no value until written. While a result waits with rsp_tready
// low the whole pipeline holds and req_tready drops; nothing is lost or
// repeated.
// ----------------------------------------------------------------------------
`include "section_region_address_translator_assert.svh"

module section_region_address_translator
   import srat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // entry_slot, new_virtual_base, new_virtual_span, new_raw_base, new_raw_span,
   // lookup_address, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // func
   input  logic [FUNC_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // region_index, translated_address, offset_in_region, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // hit
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_W-1:0]     csr_data
);

   // Region table, with end addresses precomputed at write time.
   logic [ADDR_W-1:0] vbase_ff [LANES];
   logic [ADDR_W-1:0] vend_ff  [LANES];
   logic [ADDR_W-1:0] rbase_ff [LANES];
   logic [ADDR_W-1:0] rend_ff  [LANES];
   logic [ADDR_W-1:0] vbase_in, vend_in, rbase_in, rend_in;

   logic [COUNT_W-1:0] active_ff, active_in;

   func_type          req_func;
   logic [SLOT_W-1:0] req_slot;
   logic [ADDR_W-1:0] req_addr;
   logic              advance;
   logic              query_busy;
   logic              req_accept;
   logic              table_wr;

   // Stage 1: captured request.
   logic              s1_valid_ff, s1_valid_in;
   func_type          s1_func_ff, s1_func_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;

   // Stage 2: per-lane range matches.
   logic              s2_valid_ff;
   func_type          s2_func_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [LANES-1:0]  s2_match_ff, s2_match_in;

   // Stage 3: first match as one-hot and index.
   logic              s3_valid_ff;
   func_type          s3_func_ff;
   logic [ADDR_W-1:0] s3_addr_ff;
   logic [LANES-1:0]  s3_sel_ff, s3_sel_in;
   logic              s3_hit_ff, s3_hit_in;
   logic [SLOT_W-1:0] s3_idx_ff, s3_idx_in;

   // Stage 4: selected bases.
   logic              s4_valid_ff;
   func_type          s4_func_ff;
   logic [ADDR_W-1:0] s4_addr_ff;
   logic              s4_hit_ff;
   logic [SLOT_W-1:0] s4_idx_ff;
   logic [ADDR_W-1:0] s4_base_ff, s4_base_in;
   logic [ADDR_W-1:0] s4_other_ff, s4_other_in;

   // Stage 5: offset inside the region.
   logic              s5_valid_ff;
   func_type          s5_func_ff;
   logic [ADDR_W-1:0] s5_addr_ff;
   logic              s5_hit_ff;
   logic [SLOT_W-1:0] s5_idx_ff;
   logic [ADDR_W-1:0] s5_other_ff;
   logic [ADDR_W-1:0] s5_off_ff, s5_off_in;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [ADDR_W-1:0]  rsp_xlat_ff, rsp_xlat_in;
   logic [ADDR_W-1:0]  rsp_off_ff;

   assign req_func = func_type'(req_tuser);
   assign req_slot = req_tdata[REQ_SLOT_LSB +: SLOT_W];
   assign req_addr = req_tdata[REQ_ADDR_LSB +: ADDR_W];

   // The pipeline moves as one; it holds only while a result waits unread.
   assign advance = !rsp_valid_ff || rsp_tready;

   // Lookups read the table again in the select stage, so a write may not
   // overtake a lookup that has not passed that stage yet.
   assign query_busy = (s1_valid_ff && is_query(s1_func_ff)) ||
                       (s2_valid_ff && is_query(s2_func_ff)) ||
                       (s3_valid_ff && is_query(s3_func_ff));

   assign req_tready = advance && !(req_func == FUNC_WRITE && query_busy);
   assign req_accept = req_tvalid && req_tready;
   assign table_wr   = req_accept && (req_func == FUNC_WRITE) &&
                       ({1'b0, req_slot} < (SLOT_W+1)'(LANES));

   assign vbase_in = req_tdata[REQ_VBASE_LSB +: ADDR_W];
   assign vend_in  = vbase_in + req_tdata[REQ_VSPAN_LSB +: ADDR_W];
   assign rbase_in = req_tdata[REQ_RBASE_LSB +: ADDR_W];
   assign rend_in  = rbase_in + req_tdata[REQ_RSPAN_LSB +: ADDR_W];

   assign csr_ready = 1'b1;
   assign active_in = csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (table_wr) begin
         vbase_ff[req_slot] <= vbase_in;
         vend_ff[req_slot]  <= vend_in;
         rbase_ff[req_slot] <= rbase_in;
         rend_ff[req_slot]  <= rend_in;
      end
   end

   // Stage 1 inputs.
   assign s1_valid_in = req_accept;
   assign s1_func_in  = req_func;
   assign s1_addr_in  = req_addr;

   // Stage 2: one range compare per table entry.
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      assign lo = (s1_func_ff == FUNC_REV) ? rbase_ff[i] : vbase_ff[i];
      assign hi = (s1_func_ff == FUNC_REV) ? rend_ff[i]  : vend_ff[i];
      assign s2_match_in[i] = is_query(s1_func_ff) && (COUNT_W'(i) < active_ff) &&
                              (s1_addr_ff >= lo) && (s1_addr_ff < hi);
   end

   // Stage 3: isolate the lowest matching entry.
   always_comb begin
      s3_sel_in = s2_match_ff & (~s2_match_ff + LANES'(1));
      s3_hit_in = |s2_match_ff;
      s3_idx_in = '0;
      for (int i = 0; i < LANES; i++) begin
         if (s3_sel_in[i]) begin
            s3_idx_in = s3_idx_in | SLOT_W'(i);
         end
      end
   end

   // Stage 4: AND-OR select of the matched entry's bases.
   always_comb begin
      s4_base_in  = '0;
      s4_other_in = '0;
      for (int i = 0; i < LANES; i++) begin
         if (s3_func_ff == FUNC_REV) begin
            s4_base_in  = s4_base_in  | ({ADDR_W{s3_sel_ff[i]}} & rbase_ff[i]);
            s4_other_in = s4_other_in | ({ADDR_W{s3_sel_ff[i]}} & vbase_ff[i]);
         end else begin
            s4_base_in  = s4_base_in  | ({ADDR_W{s3_sel_ff[i]}} & vbase_ff[i]);
            s4_other_in = s4_other_in | ({ADDR_W{s3_sel_ff[i]}} & rbase_ff[i]);
         end
      end
   end

   // Stage 5: offset inside the matched region.
   assign s5_off_in = s4_hit_ff ? (s4_addr_ff - s4_base_ff) : '0;

   // Output stage: translated address; a forward miss passes the address on.
   always_comb begin
      rsp_idx_in = s5_hit_ff ? {1'b0, s5_idx_ff} : INDEX_MISS;
      if (s5_hit_ff) begin
         rsp_xlat_in = s5_other_ff + s5_off_ff;
      end else if (s5_func_ff == FUNC_FWD) begin
         rsp_xlat_in = s5_addr_ff;
      end else begin
         rsp_xlat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_func_ff  <= s1_func_in;
         s1_addr_ff  <= s1_addr_in;

         s2_func_ff  <= s1_func_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_match_ff <= s2_match_in;

         s3_func_ff  <= s2_func_ff;
         s3_addr_ff  <= s2_addr_ff;
         s3_sel_ff   <= s3_sel_in;
         s3_hit_ff   <= s3_hit_in;
         s3_idx_ff   <= s3_idx_in;

         s4_func_ff  <= s3_func_ff;
         s4_addr_ff  <= s3_addr_ff;
         s4_hit_ff   <= s3_hit_ff;
         s4_idx_ff   <= s3_idx_ff;
         s4_base_ff  <= s4_base_in;
         s4_other_ff <= s4_other_in;

         s5_func_ff  <= s4_func_ff;
         s5_addr_ff  <= s4_addr_ff;
         s5_hit_ff   <= s4_hit_ff;
         s5_idx_ff   <= s4_idx_ff;
         s5_other_ff <= s4_other_ff;
         s5_off_ff   <= s5_off_in;

         rsp_hit_ff  <= s5_hit_ff;
         rsp_idx_ff  <= rsp_idx_in;
         rsp_xlat_ff <= rsp_xlat_in;
         rsp_off_ff  <= s5_off_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_USED_W){1'b0}}, rsp_off_ff, rsp_xlat_ff, rsp_idx_ff};

   `SRAT_ASSERT(a_first_match_onehot, s3_valid_ff && s3_hit_ff |-> $onehot(s3_sel_ff), "first match select is not one-hot")
   `SRAT_ASSERT(a_hit_only_on_lookup, s3_valid_ff && s3_hit_ff |-> s3_func_ff == FUNC_FWD || s3_func_ff == FUNC_REV, "hit raised for a non-lookup item")
   `SRAT_ASSERT(a_hit_has_index, rsp_valid_ff && rsp_hit_ff |-> rsp_idx_ff != INDEX_MISS, "hit returned with the miss index")
   `SRAT_ASSERT(a_miss_zero_offset, rsp_valid_ff && !rsp_hit_ff |-> rsp_off_ff == '0 && rsp_idx_ff == INDEX_MISS, "miss returned a nonzero offset or an index")
   `SRAT_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid_ff && !s1_valid_ff && active_ff == '0, "reset left the pipeline or count set")

endmodule
